[hw/rtl/wtvc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtvc_pkg
// Shared constants and types of the waypoint tracking velocity control unit.
// ----------------------------------------------------------------------------
package wtvc_pkg;

   localparam int MAX_WAYPOINTS = 16;
   localparam int WP_IDX_W      = $clog2(MAX_WAYPOINTS);
   localparam int WP_CNT_W      = 5;
   localparam int CSR_IDX_W     = 2;
   localparam int CSR_DATA_W    = 15;

   // shared divide / square-root unit
   localparam int IT_NUM_W  = 44;
   localparam int IT_DEN_W  = 32;
   localparam int IT_REM_W  = 34;
   localparam int IT_ROOT_W = IT_NUM_W / 2;
   localparam int IT_CNT_W  = $clog2(IT_NUM_W);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEED_GAIN      = 2'd0,
      CSR_OFFSET_DISTANCE = 2'd1,
      CSR_ARRIVAL_RADIUS  = 2'd2,
      CSR_WAYPOINT_COUNT  = 2'd3
   } csr_idx_type;

   typedef enum logic {
      IT_DIV  = 1'b0,
      IT_SQRT = 1'b1
   } it_op_type;

   typedef struct packed {
      logic      start;
      it_op_type op;
   } it_ctl_type;

   typedef enum logic [5:0] {
      ST_IDLE, ST_RD, ST_EX, ST_M1, ST_M2, ST_M3, ST_SQD,
      ST_Q1, ST_Q2, ST_Q3, ST_Q4, ST_Q5, ST_Q6, ST_Q7, ST_Q8, ST_Q9,
      ST_SQR, ST_CS0, ST_CSW, ST_SN0, ST_SNW,
      ST_L1, ST_L2, ST_L3, ST_L4, ST_L5, ST_L6, ST_L7,
      ST_DL0, ST_DLW, ST_DA0, ST_DAW, ST_OUT
   } state_type;

endpackage

[hw/rtl/wtvc_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtvc_req_if / wtvc_rsp_if
// Valid/ready channels for request and response beats.
// ----------------------------------------------------------------------------
interface wtvc_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic        [3:0]  waypoint_slot;
   logic signed [15:0] coord_x;
   logic signed [15:0] coord_y;
   logic signed [15:0] quat_x;
   logic signed [15:0] quat_y;
   logic signed [15:0] quat_z;
   logic signed [15:0] quat_w;

   modport source (output valid, req_type, waypoint_slot, coord_x, coord_y,
                   quat_x, quat_y, quat_z, quat_w, input ready);
   modport sink   (input valid, req_type, waypoint_slot, coord_x, coord_y,
                   quat_x, quat_y, quat_z, quat_w, output ready);
endinterface

interface wtvc_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [15:0] linear_speed;
   logic signed [15:0] angular_speed;
   logic        [3:0]  target_index;
   logic               route_finished;
   logic               zero_distance;

   modport source (output valid, linear_speed, angular_speed, target_index,
                   route_finished, zero_distance, input ready);
   modport sink   (input valid, linear_speed, angular_speed, target_index,
                   route_finished, zero_distance, output ready);
endinterface

[hw/rtl/wtvc_divsqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wtvc_divsqrt
// Shared bit-serial unsigned divider and integer square root, one
// subtractor, one quotient bit or one root bit per cycle.
// ----------------------------------------------------------------------------
module wtvc_divsqrt (
   input  logic                          clock,
   input  logic                          reset,
   input  wtvc_pkg::it_ctl_type          ctl,
   input  logic [wtvc_pkg::IT_NUM_W-1:0] num,
   input  logic [wtvc_pkg::IT_DEN_W-1:0] den,
   output logic                          done,
   output logic [wtvc_pkg::IT_NUM_W-1:0] res
);
   import wtvc_pkg::*;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   it_op_type             op_ff, op_in;
   logic [IT_CNT_W-1:0]   cnt_ff, cnt_in;
   logic [IT_NUM_W-1:0]   work_ff, work_in;
   logic [IT_DEN_W-1:0]   den_ff, den_in;
   logic [IT_REM_W-1:0]   rem_ff, rem_in;
   logic [IT_ROOT_W-1:0]  root_ff, root_in;
   logic [IT_REM_W-1:0]   rs, sub;
   logic [IT_REM_W:0]     diff;
   logic                  ge;

   always_comb begin
      if (op_ff == IT_DIV) begin
         rs  = {rem_ff[IT_REM_W-2:0], work_ff[IT_NUM_W-1]};
         sub = IT_REM_W'(den_ff);
      end else begin
         rs  = {rem_ff[IT_REM_W-3:0], work_ff[IT_NUM_W-1 -: 2]};
         sub = IT_REM_W'({root_ff, 2'b01});
      end
      diff = {1'b0, rs} - {1'b0, sub};
      ge   = ~diff[IT_REM_W];
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      op_in   = op_ff;
      cnt_in  = cnt_ff;
      work_in = work_ff;
      den_in  = den_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (ctl.start) begin
         busy_in = 1'b1;
         op_in   = ctl.op;
         cnt_in  = (ctl.op == IT_DIV) ? IT_CNT_W'(IT_NUM_W - 1) : IT_CNT_W'(IT_ROOT_W - 1);
         work_in = num;
         den_in  = den;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rem_in = ge ? diff[IT_REM_W-1:0] : rs;
         if (op_ff == IT_DIV) begin
            work_in = {work_ff[IT_NUM_W-2:0], ge};
         end else begin
            work_in = {work_ff[IT_NUM_W-3:0], 2'b00};
            root_in = {root_ff[IT_ROOT_W-2:0], ge};
         end
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff   <= op_in;
      cnt_ff  <= cnt_in;
      work_ff <= work_in;
      den_ff  <= den_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign res  = (op_ff == IT_DIV) ? work_ff : IT_NUM_W'(root_ff);

   a_start_idle: assert property (@(posedge clock) disable iff (reset)
      ctl.start |-> !busy_ff) else $error("divsqrt started while busy");
   a_done_idle: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> !busy_ff) else $error("divsqrt done while busy");
   a_done_pulse: assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff) else $error("divsqrt done longer than a cycle");

endmodule

[hw/rtl/waypoint_tracking_velocity_control_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_tracking_velocity_control_unit
// Waypoint follower: route table, heading from quaternion, arrival check,
// forward speed and point-offset turn rate, all through one multiplier and
// one bit-serial divide / square-root unit.
// ----------------------------------------------------------------------------
// A load beat writes a route slot and goes straight to the output state. A
// pose beat runs the sequencer through two or three 22-step square roots and
// up to four 44-step divisions on the shared divide / square-root unit: a
// third root when a waypoint is reached, and two divisions fewer when the
// route is finished, the robot sits on the target or the quaternion is
// degenerate. The request channel is ready only between items; a finished
// response waits in its output register without blocking the next request.
// ----------------------------------------------------------------------------
module waypoint_tracking_velocity_control_unit (
   input  logic                            clock,
   input  logic                            reset,
   wtvc_req_if.sink                        req,
   wtvc_rsp_if.source                      rsp,
   input  logic                            csr_we,
   input  logic [wtvc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [wtvc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import wtvc_pkg::*;

   function automatic logic signed [19:0] trunc14(input logic signed [33:0] v);
      logic signed [33:0] t;
      t = v + (v[33] ? 34'sd16383 : 34'sd0);
      return t[33:14];
   endfunction

   function automatic logic signed [15:0] sat16(input logic neg,
                                                input logic [IT_NUM_W-1:0] q);
      logic signed [15:0] r;
      if (!neg) r = (q > IT_NUM_W'(32767)) ? 16'sh7FFF : $signed(q[15:0]);
      else      r = (q > IT_NUM_W'(32768)) ? 16'sh8000 : -$signed(q[15:0]);
      return r;
   endfunction

   state_type              state_ff, state_in;
   logic [31:0]            tbl_mem [MAX_WAYPOINTS];
   logic [31:0]            rd_ff;
   logic [WP_IDX_W-1:0]    target_ff, target_in;
   logic                   fin_ff, fin_in;
   logic                   pass_ff, pass_in;
   logic [7:0]             gain_ff;
   logic [14:0]            od_ff, rad_ff;
   logic [WP_CNT_W-1:0]    cnt_ff;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic signed [15:0]     out_lin_ff, out_ang_ff;
   logic [WP_IDX_W-1:0]    out_tgt_ff;
   logic                   out_fin_ff, out_zd_ff;
   logic                   out_load;

   logic signed [15:0]     px_ff, py_ff, qx_ff, qy_ff, qz_ff, qw_ff;
   logic signed [16:0]     ex_ff, ex_in, ey_ff, ey_in;
   logic signed [55:0]     acc_ff, acc_in, prod_ff, prod_in;
   logic [16:0]            dist_ff, dist_in;
   logic signed [33:0]     s_ff, s_in, c_ff, c_in;
   logic signed [19:0]     s14_ff, s14_in, c14_ff, c14_in;
   logic [19:0]            r_ff, r_in;
   logic signed [15:0]     cs_ff, cs_in, sn_ff, sn_in;
   logic signed [33:0]     dot_ff, dot_in, crs_ff, crs_in;
   logic signed [41:0]     numl_ff, numl_in, numa_ff, numa_in;
   logic signed [15:0]     lin_ff, lin_in, ang_ff, ang_in;
   logic                   zd_ff, zd_in;

   logic signed [35:0]     mul_a;
   logic signed [19:0]     mul_b;
   logic signed [55:0]     sum_ap;
   logic                   accept, load_acc;
   logic [WP_CNT_W-1:0]    cnt_clamp;
   logic [14:0]            od_eff;
   logic [19:0]            c14_mag, s14_mag;
   logic [41:0]            numl_mag, numa_mag;

   it_ctl_type             it_ctl;
   logic [IT_NUM_W-1:0]    it_num, it_res;
   logic [IT_DEN_W-1:0]    it_den;
   logic                   it_done;

   wtvc_divsqrt u_divsqrt (
      .clock (clock),
      .reset (reset),
      .ctl   (it_ctl),
      .num   (it_num),
      .den   (it_den),
      .done  (it_done),
      .res   (it_res)
   );

   assign accept    = req.valid && req.ready;
   assign load_acc  = accept && !req.req_type;
   assign req.ready = (state_ff == ST_IDLE);
   assign sum_ap    = acc_ff + prod_ff;
   assign cnt_clamp = (cnt_ff > WP_CNT_W'(MAX_WAYPOINTS)) ? WP_CNT_W'(MAX_WAYPOINTS) : cnt_ff;
   assign od_eff    = (od_ff == '0) ? 15'd1 : od_ff;
   assign c14_mag   = c14_ff[19] ? 20'(-c14_ff) : 20'(c14_ff);
   assign s14_mag   = s14_ff[19] ? 20'(-s14_ff) : 20'(s14_ff);
   assign numl_mag  = numl_ff[41] ? 42'(-numl_ff) : 42'(numl_ff);
   assign numa_mag  = numa_ff[41] ? 42'(-numa_ff) : 42'(numa_ff);
   assign prod_in   = mul_a * mul_b;

   always_comb begin
      state_in     = state_ff;
      target_in    = target_ff;
      fin_in       = fin_ff;
      pass_in      = pass_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      out_load     = 1'b0;
      ex_in   = ex_ff;   ey_in   = ey_ff;   acc_in  = acc_ff;  dist_in = dist_ff;
      s_in    = s_ff;    c_in    = c_ff;    s14_in  = s14_ff;  c14_in  = c14_ff;
      r_in    = r_ff;    cs_in   = cs_ff;   sn_in   = sn_ff;   dot_in  = dot_ff;
      crs_in  = crs_ff;  numl_in = numl_ff; numa_in = numa_ff;
      lin_in  = lin_ff;  ang_in  = ang_ff;  zd_in   = zd_ff;
      mul_a   = 36'(ex_ff);
      mul_b   = 20'(ex_ff);
      it_ctl  = '{start: 1'b0, op: IT_DIV};
      it_num  = sum_ap[IT_NUM_W-1:0];
      it_den  = IT_DEN_W'(r_ff);

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               pass_in = 1'b0;
               if (!req.req_type) begin
                  if (req.waypoint_slot == '0) begin
                     target_in = '0;
                     fin_in    = 1'b0;
                  end
                  lin_in   = '0;
                  ang_in   = '0;
                  zd_in    = 1'b0;
                  state_in = ST_OUT;
               end else begin
                  state_in = ST_RD;
               end
            end
         end
         ST_RD: state_in = ST_EX;
         ST_EX: begin
            ex_in    = 17'($signed(rd_ff[15:0])) - 17'(px_ff);
            ey_in    = 17'($signed(rd_ff[31:16])) - 17'(py_ff);
            state_in = ST_M1;
         end
         ST_M1: begin
            mul_a    = 36'(ex_ff);
            mul_b    = 20'(ex_ff);
            state_in = ST_M2;
         end
         ST_M2: begin
            acc_in   = prod_ff;
            mul_a    = 36'(ey_ff);
            mul_b    = 20'(ey_ff);
            state_in = ST_M3;
         end
         ST_M3: begin
            it_ctl   = '{start: 1'b1, op: IT_SQRT};
            state_in = ST_SQD;
         end
         ST_SQD: begin
            if (it_done) begin
               dist_in  = it_res[16:0];
               state_in = ST_Q1;
               if (!pass_ff && (it_res[16:0] <= 17'(rad_ff))) begin
                  if ((WP_CNT_W'(target_ff) + 1'b1) < cnt_clamp) begin
                     target_in = target_ff + 1'b1;
                     pass_in   = 1'b1;
                     state_in  = ST_RD;
                  end else begin
                     fin_in = 1'b1;
                  end
               end
            end
         end
         ST_Q1: begin
            mul_a    = 36'(qw_ff);
            mul_b    = 20'(qz_ff);
            state_in = ST_Q2;
         end
         ST_Q2: begin
            acc_in   = prod_ff;
            mul_a    = 36'(qx_ff);
            mul_b    = 20'(qy_ff);
            state_in = ST_Q3;
         end
         ST_Q3: begin
            s_in     = sum_ap[33:0] <<< 1;
            mul_a    = 36'(qy_ff);
            mul_b    = 20'(qy_ff);
            state_in = ST_Q4;
         end
         ST_Q4: begin
            acc_in   = prod_ff;
            mul_a    = 36'(qz_ff);
            mul_b    = 20'(qz_ff);
            state_in = ST_Q5;
         end
         ST_Q5: begin
            c_in     = 34'sd268435456 - (sum_ap[33:0] <<< 1);
            state_in = ST_Q6;
         end
         ST_Q6: begin
            s14_in   = trunc14(s_ff);
            c14_in   = trunc14(c_ff);
            state_in = ST_Q7;
         end
         ST_Q7: begin
            mul_a    = 36'(s14_ff);
            mul_b    = s14_ff;
            state_in = ST_Q8;
         end
         ST_Q8: begin
            acc_in   = prod_ff;
            mul_a    = 36'(c14_ff);
            mul_b    = c14_ff;
            state_in = ST_Q9;
         end
         ST_Q9: begin
            it_ctl   = '{start: 1'b1, op: IT_SQRT};
            state_in = ST_SQR;
         end
         ST_SQR: begin
            if (it_done) begin
               r_in = it_res[19:0];
               if (it_res[19:0] == '0) begin
                  cs_in    = 16'sd16384;
                  sn_in    = '0;
                  state_in = ST_L1;
               end else begin
                  state_in = ST_CS0;
               end
            end
         end
         ST_CS0: begin
            it_ctl   = '{start: 1'b1, op: IT_DIV};
            it_num   = IT_NUM_W'({c14_mag, 14'b0});
            state_in = ST_CSW;
         end
         ST_CSW: begin
            if (it_done) begin
               cs_in    = c14_ff[19] ? -$signed(it_res[15:0]) : $signed(it_res[15:0]);
               state_in = ST_SN0;
            end
         end
         ST_SN0: begin
            it_ctl   = '{start: 1'b1, op: IT_DIV};
            it_num   = IT_NUM_W'({s14_mag, 14'b0});
            state_in = ST_SNW;
         end
         ST_SNW: begin
            if (it_done) begin
               sn_in    = s14_ff[19] ? -$signed(it_res[15:0]) : $signed(it_res[15:0]);
               state_in = ST_L1;
            end
         end
         ST_L1: begin
            zd_in = (dist_ff == '0);
            if (fin_ff || dist_ff == '0) begin
               lin_in   = '0;
               ang_in   = '0;
               state_in = ST_OUT;
            end else begin
               mul_a    = 36'(cs_ff);
               mul_b    = 20'(ex_ff);
               state_in = ST_L2;
            end
         end
         ST_L2: begin
            acc_in   = prod_ff;
            mul_a    = 36'(sn_ff);
            mul_b    = 20'(ey_ff);
            state_in = ST_L3;
         end
         ST_L3: begin
            dot_in   = sum_ap[33:0];
            mul_a    = 36'(cs_ff);
            mul_b    = 20'(ey_ff);
            state_in = ST_L4;
         end
         ST_L4: begin
            acc_in   = prod_ff;
            mul_a    = 36'(sn_ff);
            mul_b    = 20'(ex_ff);
            state_in = ST_L5;
         end
         ST_L5: begin
            crs_in   = acc_ff[33:0] - prod_ff[33:0];
            mul_a    = 36'(dot_ff);
            mul_b    = 20'($signed({1'b0, gain_ff}));
            state_in = ST_L6;
         end
         ST_L6: begin
            numl_in  = prod_ff[41:0];
            mul_a    = 36'(crs_ff);
            mul_b    = 20'($signed({1'b0, gain_ff}));
            state_in = ST_L7;
         end
         ST_L7: begin
            numa_in  = prod_ff[41:0];
            state_in = ST_DL0;
         end
         ST_DL0: begin
            it_ctl   = '{start: 1'b1, op: IT_DIV};
            it_num   = IT_NUM_W'(numl_mag);
            it_den   = IT_DEN_W'({dist_ff, 14'b0});
            state_in = ST_DLW;
         end
         ST_DLW: begin
            if (it_done) begin
               lin_in   = sat16(numl_ff[41], it_res);
               state_in = ST_DA0;
            end
         end
         ST_DA0: begin
            it_ctl   = '{start: 1'b1, op: IT_DIV};
            it_num   = IT_NUM_W'(numa_mag);
            it_den   = IT_DEN_W'({od_eff, 14'b0});
            state_in = ST_DAW;
         end
         ST_DAW: begin
            if (it_done) begin
               ang_in   = sat16(numa_ff[41], it_res);
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               out_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         target_ff    <= '0;
         fin_ff       <= 1'b0;
         pass_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         gain_ff      <= 8'd128;
         od_ff        <= 15'd128;
         rad_ff       <= 15'd26;
         cnt_ff       <= WP_CNT_W'(1);
      end else begin
         state_ff     <= state_in;
         target_ff    <= target_in;
         fin_ff       <= fin_in;
         pass_ff      <= pass_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_idx_type'(csr_index))
               CSR_SPEED_GAIN:      gain_ff <= csr_wdata[7:0];
               CSR_OFFSET_DISTANCE: od_ff   <= csr_wdata[14:0];
               CSR_ARRIVAL_RADIUS:  rad_ff  <= csr_wdata[14:0];
               CSR_WAYPOINT_COUNT:  cnt_ff  <= csr_wdata[WP_CNT_W-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_acc) begin
         tbl_mem[req.waypoint_slot] <= {req.coord_y, req.coord_x};
      end
      rd_ff <= tbl_mem[target_ff];
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         px_ff <= req.coord_x;
         py_ff <= req.coord_y;
         qx_ff <= req.quat_x;
         qy_ff <= req.quat_y;
         qz_ff <= req.quat_z;
         qw_ff <= req.quat_w;
      end
      ex_ff   <= ex_in;   ey_ff   <= ey_in;   acc_ff  <= acc_in;  prod_ff <= prod_in;
      dist_ff <= dist_in; s_ff    <= s_in;    c_ff    <= c_in;    s14_ff  <= s14_in;
      c14_ff  <= c14_in;  r_ff    <= r_in;    cs_ff   <= cs_in;   sn_ff   <= sn_in;
      dot_ff  <= dot_in;  crs_ff  <= crs_in;  numl_ff <= numl_in; numa_ff <= numa_in;
      lin_ff  <= lin_in;  ang_ff  <= ang_in;  zd_ff   <= zd_in;
      if (out_load) begin
         out_lin_ff <= lin_ff;
         out_ang_ff <= ang_ff;
         out_tgt_ff <= target_ff;
         out_fin_ff <= fin_ff;
         out_zd_ff  <= zd_ff;
      end
   end

   assign rsp.valid          = rsp_valid_ff;
   assign rsp.linear_speed   = out_lin_ff;
   assign rsp.angular_speed  = out_ang_ff;
   assign rsp.target_index   = out_tgt_ff;
   assign rsp.route_finished = out_fin_ff;
   assign rsp.zero_distance  = out_zd_ff;

   a_restart: assert property (@(posedge clock) disable iff (reset)
      (load_acc && req.waypoint_slot == '0) |=> (target_ff == '0 && !fin_ff))
      else $error("slot 0 load did not restart the route");
   a_fin_sticky: assert property (@(posedge clock) disable iff (reset)
      $fell(fin_ff) |-> $past(load_acc && req.waypoint_slot == '0))
      else $error("finished flag cleared without route restart");
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_OUT))
      else $error("response beat raised outside output state");

endmodule

[tb/waypoint_tracking_velocity_control_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// waypoint_tracking_velocity_control_unit_tb
// Drives route loads and pose samples into the waypoint follower, predicts
// every response beat in fixed point and checks it field by field. Random
// bursts on the request side, random stalls on the response side, register
// changes between phases.
// ----------------------------------------------------------------------------
module waypoint_tracking_velocity_control_unit_tb;
   import wtvc_pkg::*;

   typedef struct {
      logic               is_pose;
      logic [3:0]         slot;
      logic signed [15:0] x, y, qx, qy, qz, qw;
   } beat_type;

   typedef struct {
      logic signed [15:0] lin, ang;
      logic [3:0]         tgt;
      logic               fin, zdist;
   } cmd_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic                  csr_we    = 1'b0;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   wtvc_req_if req ();
   wtvc_rsp_if rsp ();

   waypoint_tracking_velocity_control_unit DUT (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   beat_type pending_beats[$];
   cmd_type  expected_cmds[$];
   int    errors = 0;
   int    beats_queued = 0;

   // predictor state
   logic signed [15:0] route_x[MAX_WAYPOINTS];
   logic signed [15:0] route_y[MAX_WAYPOINTS];
   int unsigned tgt_q, fin_q, gain_q, offd_q, arad_q, wcnt_q;

   function automatic longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   function automatic longint clip16(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return v;
   endfunction

   function automatic cmd_type steer(beat_type b);
      cmd_type o;
      longint ex, ey, s, c, s14, c14, cs, sn, od;
      longint unsigned d, r;
      int unsigned cnt, idx;
      o.lin = 0; o.ang = 0; o.zdist = 0;
      if (!b.is_pose) begin
         route_x[b.slot] = b.x;
         route_y[b.slot] = b.y;
         if (b.slot == 0) begin
            tgt_q = 0;
            fin_q = 0;
         end
      end else begin
         cnt = (wcnt_q > MAX_WAYPOINTS) ? MAX_WAYPOINTS : wcnt_q;
         idx = tgt_q % MAX_WAYPOINTS;
         ex = longint'(route_x[idx]) - longint'(b.x);
         ey = longint'(route_y[idx]) - longint'(b.y);
         d = int_sqrt(longint'(ex * ex + ey * ey));
         if (d <= arad_q) begin
            if (idx + 1 < cnt) begin
               tgt_q = idx + 1;
               idx = tgt_q;
               ex = longint'(route_x[idx]) - longint'(b.x);
               ey = longint'(route_y[idx]) - longint'(b.y);
               d = int_sqrt(longint'(ex * ex + ey * ey));
            end else begin
               fin_q = 1;
            end
         end
         s = 2 * (longint'(b.qw) * b.qz + longint'(b.qx) * b.qy);
         c = (longint'(1) << 28) - 2 * (longint'(b.qy) * b.qy + longint'(b.qz) * b.qz);
         s14 = s / 16384;
         c14 = c / 16384;
         r = int_sqrt(longint'(s14 * s14 + c14 * c14));
         cs = 16384;
         sn = 0;
         od = (offd_q == 0) ? 1 : offd_q;
         if (r != 0) begin
            cs = (c14 * 16384) / longint'(r);
            sn = (s14 * 16384) / longint'(r);
         end
         o.zdist = (d == 0);
         if (fin_q == 0 && d != 0) begin
            o.lin = clip16((longint'(gain_q) * (cs * ex + sn * ey)) / (longint'(d) * 16384));
            o.ang = clip16((longint'(gain_q) * (cs * ey - sn * ex)) / (od * 16384));
         end
      end
      o.tgt = tgt_q[3:0];
      o.fin = fin_q[0];
      return o;
   endfunction

   // request side: acceptance, register shadow, response check
   logic req_taken = 1'b0;
   always @(posedge clock) begin
      cmd_type e;
      req_taken <= req.valid && req.ready;
      if (csr_we) begin
         case (csr_idx_type'(csr_index))
            CSR_SPEED_GAIN:      gain_q = csr_wdata[7:0];
            CSR_OFFSET_DISTANCE: offd_q = csr_wdata;
            CSR_ARRIVAL_RADIUS:  arad_q = csr_wdata;
            CSR_WAYPOINT_COUNT:  wcnt_q = csr_wdata[4:0];
         endcase
      end
      if (!reset && req.valid && req.ready) begin
         expected_cmds.push_back(steer(pending_beats[0]));
         void'(pending_beats.pop_front());
      end
      if (!reset && rsp.valid && rsp.ready) begin
         if (expected_cmds.size() == 0) begin
            $error("response beat with nothing expected");
            errors++;
         end else begin
            e = expected_cmds.pop_front();
            if (rsp.linear_speed !== e.lin) begin
               $error("linear_speed exp %0d got %0d", e.lin, rsp.linear_speed); errors++;
            end
            if (rsp.angular_speed !== e.ang) begin
               $error("angular_speed exp %0d got %0d", e.ang, rsp.angular_speed); errors++;
            end
            if (rsp.target_index !== e.tgt) begin
               $error("target_index exp %0d got %0d", e.tgt, rsp.target_index); errors++;
            end
            if (rsp.route_finished !== e.fin) begin
               $error("route_finished exp %0d got %0d", e.fin, rsp.route_finished); errors++;
            end
            if (rsp.zero_distance !== e.zdist) begin
               $error("zero_distance exp %0d got %0d", e.zdist, rsp.zero_distance); errors++;
            end
         end
      end
   end

   // driver: bursts and gaps
   int burst_left = 1, gap_left = 0;
   initial begin
      req.valid = 1'b0; req.req_type = 1'b0; req.waypoint_slot = '0;
      req.coord_x = '0; req.coord_y = '0;
      req.quat_x = '0; req.quat_y = '0; req.quat_z = '0; req.quat_w = '0;
      rsp.ready = 1'b0;
   end

   always @(negedge clock) begin
      if (req_taken) begin
         burst_left--;
         if (burst_left <= 0) begin
            burst_left = $urandom_range(1, 30);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 400);
         end
      end
      if (req.valid && !req_taken) begin
         // hold until accepted
      end else if (gap_left > 0) begin
         gap_left--;
         req.valid <= 1'b0;
      end else if (pending_beats.size() > 0) begin
         req.valid         <= 1'b1;
         req.req_type      <= pending_beats[0].is_pose;
         req.waypoint_slot <= pending_beats[0].slot;
         req.coord_x       <= pending_beats[0].x;
         req.coord_y       <= pending_beats[0].y;
         req.quat_x        <= pending_beats[0].qx;
         req.quat_y        <= pending_beats[0].qy;
         req.quat_z        <= pending_beats[0].qz;
         req.quat_w        <= pending_beats[0].qw;
      end else begin
         req.valid <= 1'b0;
      end
   end

   // receiver stall pattern
   int stall_mode = 0, mode_left = 0;
   always @(negedge clock) begin
      if (mode_left == 0) begin
         stall_mode = $urandom_range(0, 2);
         mode_left  = $urandom_range(50, 3000);
      end
      mode_left--;
      case (stall_mode)
         0: rsp.ready <= 1'b1;
         1: rsp.ready <= $urandom_range(0, 1);
         default: rsp.ready <= ($urandom_range(0, 15) == 0);
      endcase
   end

   task automatic add_load(int slot, int x, int y);
      beat_type b;
      b.is_pose = 1'b0; b.slot = slot; b.x = x; b.y = y;
      b.qx = $urandom; b.qy = $urandom; b.qz = $urandom; b.qw = $urandom;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   task automatic add_pose(int x, int y, int qx, int qy, int qz, int qw);
      beat_type b;
      b.is_pose = 1'b1; b.slot = $urandom; b.x = x; b.y = y;
      b.qx = qx; b.qy = qy; b.qz = qz; b.qw = qw;
      pending_beats.push_back(b);
      beats_queued++;
   endtask

   task automatic add_pose_rand_quat(int x, int y);
      int sel;
      sel = $urandom_range(0, 9);
      case (sel)
         0: add_pose(x, y, 0, 0, 0, 16384);
         1: add_pose(x, y, 0, 0, 11585, 11585);
         2: add_pose(x, y, 0, 0, 16384, 0);
         3: add_pose(x, y, 0, 0, -11585, 11585);
         4: add_pose(x, y, 0, 0, 6270, -15137);
         default: add_pose(x, y, $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384,
                           $urandom_range(0, 32768) - 16384);
      endcase
   endtask

   task automatic wait_idle();
      wait (pending_beats.size() == 0 && expected_cmds.size() == 0);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_reg(csr_idx_type idx, int value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
   endtask

   task automatic set_regs(int g, int od, int ar, int cnt);
      wait_idle();
      write_reg(CSR_SPEED_GAIN, g);
      write_reg(CSR_OFFSET_DISTANCE, od);
      write_reg(CSR_ARRIVAL_RADIUS, ar);
      write_reg(CSR_WAYPOINT_COUNT, cnt);
   endtask

   int n, px, py, ar, rx[16], ry[16];

   initial begin
      gain_q = 128; offd_q = 128; arad_q = 26; wcnt_q = 1;
      tgt_q = 0; fin_q = 0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // every slot written before any pose
      for (int i = 15; i >= 0; i--) add_load(i, 256 * i, -256 * i);
      add_pose(0, 0, 0, 0, 0, 16384);              // on target, single waypoint
      add_pose(32767, -32768, 0, 0, 0, 16384);     // finished: speeds zero
      add_load(0, -32768, 32767);                  // restart
      add_pose(32767, -32768, 16384, 16384, 16384, 16384);
      add_pose(0, 0, 0, 8192, 8192, 0);            // degenerate heading
      add_pose(100, 50, 0, 0, 0, 0);

      set_regs(255, 1, 0, 3);
      add_load(1, -32768, 32767);                  // duplicate waypoint
      add_load(0, -32768, 32767);
      add_pose(-32768, 32767, 0, 0, 0, 16384);     // arrive, next on top
      add_pose(32767, -32768, -16384, -16384, -16384, -16384);
      add_pose(32767, 32767, 0, 0, 16384, 0);
      set_regs(0, 0, 32767, 0);                    // zero gain, zero count
      add_load(0, 1000, 1000);
      add_pose(-32768, -32768, 0, 0, 11585, 11585);
      add_pose(0, 0, 0, 0, 0, 16384);
      set_regs(200, 32767, 300, 31);               // count clamped
      add_load(0, 0, 0);
      for (int i = 0; i < 16; i++) add_pose(256 * i, -256 * i, 0, 0, 0, 16384);
      add_pose(5, 5, 0, 0, 0, 16384);

      while (beats_queued < 1150) begin
         n  = ($urandom_range(0, 7) == 0) ? 16 : $urandom_range(1, 6);
         ar = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 1500);
         set_regs($urandom_range(0, 255),
                  ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(1, 2000),
                  ar, ($urandom_range(0, 9) == 0) ? $urandom_range(0, 31) : n);
         for (int i = 0; i < n; i++) begin
            rx[i] = $urandom_range(0, 16000) - 8000;
            ry[i] = $urandom_range(0, 16000) - 8000;
            add_load(i, rx[i], ry[i]);
         end
         for (int i = 0; i < n; i++) begin
            repeat ($urandom_range(1, 3)) begin
               px = rx[i] + $urandom_range(0, 3000) - 1500;
               py = ry[i] + $urandom_range(0, 3000) - 1500;
               add_pose_rand_quat(px, py);
            end
            px = rx[i] + $urandom_range(0, ar / 2 + 1) - ar / 4;
            py = ry[i] + $urandom_range(0, ar / 2 + 1) - ar / 4;
            if ($urandom_range(0, 4) == 0) begin
               px = rx[i]; py = ry[i];
            end
            add_pose_rand_quat(px, py);
         end
         repeat ($urandom_range(0, 4)) begin
            case ($urandom_range(0, 2))
               0: add_load($urandom_range(0, 15), $urandom_range(0, 65535) - 32768,
                           $urandom_range(0, 65535) - 32768);
               default: add_pose_rand_quat($urandom_range(0, 65535) - 32768,
                                           $urandom_range(0, 65535) - 32768);
            endcase
         end
      end

      wait (pending_beats.size() == 0 && expected_cmds.size() == 0);
      repeat (400) @(posedge clock);
      if (errors == 0 && expected_cmds.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #50ms;
      $display("FAIL");
      $finish;
   end

endmodule
